FILE: design/lws_pkg.sv
// ----------------------------------------------------------------------------
// lws_pkg
// Shared types and constants of the lookahead waypoint selector: register
// widths, reset values and indexes, action codes, sequencer states and the
// control structs passed between the sequencer, the distance pipe and the top.
// ----------------------------------------------------------------------------
package lws_pkg;

  localparam int LOOK_W     = 16;
  localparam int MARGIN_W   = 8;
  localparam int LIMIT_W    = 23;
  localparam int CFG_W      = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int TIDX_W     = 8;
  localparam int LOOK_SQ_W  = 2 * LOOK_W;
  localparam int LIMIT_SQ_W = 2 * LIMIT_W;

  localparam logic [LOOK_W-1:0]   LOOK_RST   = 16'd320;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd10;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 23'd64000;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM,
    ST_CHECK,
    ST_NEAR,
    ST_WALK,
    ST_FETCH,
    ST_OUT
  } lws_state_t;

  // one read travelling through the distance pipe
  typedef struct packed {
    logic valid;
    logic last;
  } lws_tag_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic setpoint_valid;
    logic path_done;
  } lws_res_t;

endpackage

FILE: design/lws_point_mem.sv
// ----------------------------------------------------------------------------
// lws_point_mem
// Waypoint store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lws_point_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: design/lws_dist_pipe.sv
// ----------------------------------------------------------------------------
// lws_dist_pipe
// Squared distance pipe: tag aligned with the memory read, then absolute
// differences, squares, and 2D / 3D sums.
// ----------------------------------------------------------------------------
module lws_dist_pipe import lws_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int AW         = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    flush,
  input  lws_tag_t                iss_tag,
  input  logic [AW-1:0]           iss_addr,
  input  logic [3*COORD_BITS-1:0] rd_data,
  input  logic [COORD_BITS-1:0]   pos_x,
  input  logic [COORD_BITS-1:0]   pos_y,
  input  logic [COORD_BITS-1:0]   pos_z,
  output lws_tag_t                res_tag,
  output logic [AW-1:0]           res_addr,
  output logic [2*COORD_BITS+1:0] res_d2,
  output logic [2*COORD_BITS+1:0] res_d3
);

  localparam int N  = COORD_BITS;
  localparam int DW = 2 * N + 2;

  lws_tag_t tag0_r, tag1_r, tag2_r, tag3_r;
  logic [AW-1:0] addr0_r, addr1_r, addr2_r, addr3_r;
  logic [N-1:0] ax_r, ay_r, az_r;
  logic [2*N-1:0] sx_r, sy_r, sz_r;
  logic [DW-1:0] d2_r, d3_r;

  function automatic logic [N-1:0] abs_diff(input logic [N-1:0] a, input logic [N-1:0] b);
    logic [N:0] d;
    d = {a[N-1], a} - {b[N-1], b};
    abs_diff = d[N] ? N'(~d + 1'b1) : d[N-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (flush) begin
      // drop everything in flight, including this cycle's read
      tag0_r <= '0;
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag0_r <= iss_tag;
      tag1_r <= tag0_r;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    addr0_r <= iss_addr;
    addr1_r <= addr0_r;
    addr2_r <= addr1_r;
    addr3_r <= addr2_r;
    ax_r    <= abs_diff(rd_data[N-1:0], pos_x);
    ay_r    <= abs_diff(rd_data[2*N-1:N], pos_y);
    az_r    <= abs_diff(rd_data[3*N-1:2*N], pos_z);
    sx_r    <= (2*N)'(ax_r) * (2*N)'(ax_r);
    sy_r    <= (2*N)'(ay_r) * (2*N)'(ay_r);
    sz_r    <= (2*N)'(az_r) * (2*N)'(az_r);
    d2_r    <= DW'(sx_r) + DW'(sy_r);
    d3_r    <= DW'(sx_r) + DW'(sy_r) + DW'(sz_r);
  end

  assign res_tag  = tag3_r;
  assign res_addr = addr3_r;
  assign res_d2   = d2_r;
  assign res_d3   = d3_r;

endmodule

FILE: design/lws_ctrl.sv
// ----------------------------------------------------------------------------
// lws_ctrl
// Sequencer: path bookkeeping, memory writes on append, read sweeps for the
// trim and nearest searches, the forward walk, and the target fetch.
// ----------------------------------------------------------------------------
module lws_ctrl import lws_pkg::*; #(
  parameter int PATH_DEPTH = 256,
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_xfer,
  input  logic                          in_action,
  input  logic                          in_first,
  input  logic                          in_last,
  input  logic [3*COORD_BITS-1:0]       in_coords,
  input  logic [LOOK_SQ_W-1:0]          look_sq,
  input  logic [LIMIT_SQ_W-1:0]         limit_sq,
  input  logic [MARGIN_W-1:0]           end_margin,
  output logic                          in_ready,
  output logic                          mem_we,
  output logic [$clog2(PATH_DEPTH)-1:0] mem_waddr,
  output logic [3*COORD_BITS-1:0]       mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(PATH_DEPTH)-1:0] mem_raddr,
  input  logic [3*COORD_BITS-1:0]       mem_rdata,
  output lws_tag_t                      iss_tag,
  output logic [$clog2(PATH_DEPTH)-1:0] iss_addr,
  output logic                          flush,
  input  lws_tag_t                      res_tag,
  input  logic [$clog2(PATH_DEPTH)-1:0] res_addr,
  input  logic [2*COORD_BITS+1:0]       res_d2,
  input  logic [2*COORD_BITS+1:0]       res_d3,
  input  logic                          out_free,
  output lws_res_t                      res_out,
  output logic [TIDX_W-1:0]             res_index,
  output logic [3*COORD_BITS-1:0]       res_coords
);

  localparam int AW   = $clog2(PATH_DEPTH);
  localparam int LENW = $clog2(PATH_DEPTH + 1);
  localparam int DW   = 2 * COORD_BITS + 2;
  localparam int CMPW = (DW > LIMIT_SQ_W) ? DW : LIMIT_SQ_W;
  localparam int LKW  = (DW > LOOK_SQ_W) ? DW : LOOK_SQ_W;
  localparam int KW   = ((LENW > MARGIN_W) ? LENW : MARGIN_W) + 1;
  localparam logic [LENW-1:0] DEPTH_LEN = LENW'(PATH_DEPTH);

  lws_state_t state_r, state_nxt;
  logic [LENW-1:0] length_r;
  logic [AW-1:0]   base_r, track_r, iss_ptr_r, iss_end_r, best_addr_r, idx_r;
  logic            iss_on_r, done_r;
  logic [CMPW-1:0] best_r;

  logic [LENW-1:0] len_eff, length_new, path_len, len_m1;
  logic            is_update, is_append, keep, better, scan_last, near_stop, walk_hit;
  logic [AW-1:0]   pick_addr, near_rel;

  assign is_update  = in_xfer && (in_action == ACT_UPDATE);
  assign is_append  = in_xfer && (in_action == ACT_APPEND);
  assign len_eff    = in_first ? '0 : length_r;
  assign mem_we     = is_append && (len_eff < DEPTH_LEN);
  assign mem_waddr  = AW'(len_eff);
  assign mem_wdata  = in_coords;
  assign length_new = mem_we ? len_eff + 1'b1 : len_eff;

  assign path_len  = (length_r > LENW'(base_r)) ? length_r - LENW'(base_r) : '0;
  assign len_m1    = path_len - 1'b1;
  assign keep      = KW'(path_len) > (KW'(track_r) + KW'(end_margin));
  // strict compare keeps the first minimum
  assign better    = res_tag.valid && (CMPW'(res_d2) < best_r);
  assign pick_addr = better ? res_addr : best_addr_r;
  assign scan_last = res_tag.valid && res_tag.last;
  assign near_rel  = pick_addr - base_r;
  assign near_stop = (look_sq == '0) || (LENW'(near_rel) >= len_m1);
  assign walk_hit  = res_tag.valid && (res_tag.last || (LKW'(res_d3) >= LKW'(look_sq)));

  assign iss_addr = iss_ptr_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_update) begin
          state_nxt = ST_CHECK;
        end else if (is_append && in_last) begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (scan_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = keep ? ST_NEAR : ST_OUT;
      ST_NEAR: begin
        if (scan_last) state_nxt = near_stop ? ST_FETCH : ST_WALK;
      end
      ST_WALK: begin
        if (walk_hit) state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = iss_ptr_r;
    iss_tag   = '0;
    flush     = 1'b0;
    res_out   = '0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_TRIM, ST_NEAR, ST_WALK: begin
        iss_tag.valid = iss_on_r;
        iss_tag.last  = iss_on_r && (iss_ptr_r == iss_end_r);
        mem_re        = iss_on_r;
        flush         = (state_r == ST_WALK) && walk_hit;
      end
      ST_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + idx_r;
      end
      ST_OUT: begin
        res_out.load           = out_free;
        res_out.setpoint_valid = !done_r;
        res_out.path_done      = done_r;
      end
      default: begin
      end
    endcase
  end

  assign res_index  = done_r ? '0 : TIDX_W'(idx_r);
  assign res_coords = done_r ? '0 : mem_rdata;

  // Writes happen only in idle and reads only outside it, so the store
  // never sees a read and a write of the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      length_r <= '0;
      base_r   <= '0;
      track_r  <= '0;
      iss_on_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (is_append) begin
            length_r <= length_new;
            if (in_first) begin
              base_r  <= '0;
              track_r <= '0;
            end
            if (in_last) begin
              iss_ptr_r   <= '0;
              iss_end_r   <= AW'(length_new - 1'b1);
              iss_on_r    <= 1'b1;
              best_r      <= CMPW'(limit_sq);
              best_addr_r <= '0;
            end
          end
        end
        ST_TRIM: begin
          if (iss_on_r) begin
            if (iss_ptr_r == iss_end_r) iss_on_r <= 1'b0;
            else iss_ptr_r <= iss_ptr_r + 1'b1;
          end
          if (better) begin
            best_r      <= CMPW'(res_d2);
            best_addr_r <= res_addr;
          end
          if (scan_last) begin
            base_r  <= pick_addr;
            track_r <= '0;
          end
        end
        ST_CHECK: begin
          done_r <= !keep;
          if (keep) begin
            iss_ptr_r   <= base_r;
            iss_end_r   <= AW'(length_r - 1'b1);
            iss_on_r    <= 1'b1;
            best_r      <= CMPW'(limit_sq);
            best_addr_r <= base_r;
          end else begin
            length_r <= '0;
            base_r   <= '0;
            track_r  <= '0;
          end
        end
        ST_NEAR: begin
          if (iss_on_r) begin
            if (iss_ptr_r == iss_end_r) iss_on_r <= 1'b0;
            else iss_ptr_r <= iss_ptr_r + 1'b1;
          end
          if (better) begin
            best_r      <= CMPW'(res_d2);
            best_addr_r <= res_addr;
          end
          if (scan_last) begin
            idx_r <= near_rel;
            if (!near_stop) begin
              // walk starts one past the nearest point
              iss_ptr_r <= pick_addr + 1'b1;
              iss_end_r <= AW'(length_r - 1'b1);
              iss_on_r  <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (iss_on_r) begin
            if (iss_ptr_r == iss_end_r) iss_on_r <= 1'b0;
            else iss_ptr_r <= iss_ptr_r + 1'b1;
          end
          if (walk_hit) begin
            idx_r    <= res_addr - base_r;
            iss_on_r <= 1'b0;
          end
        end
        ST_FETCH: track_r <= idx_r;
        ST_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_base_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (length_r == '0) || (LENW'(base_r) < length_r))
    else $error("path base outside stored path");

  a_res_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    res_tag.valid |-> (state_r == ST_TRIM || state_r == ST_NEAR || state_r == ST_WALK))
    else $error("distance result outside a sweep");

  a_fetch_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |->
      (((LENW+1)'(base_r) + (LENW+1)'(idx_r)) < (LENW+1)'(length_r)))
    else $error("target fetch beyond path end");

endmodule

FILE: design/lookahead_waypoint_select_core.sv
// ----------------------------------------------------------------------------
// lookahead_waypoint_select_core
// Waypoint path store with lookahead setpoint selection.
//
//   channel  dir  transfer rule             contents
//   in_*     in   in_tvalid & in_tready     point append or position update
//   out_*    out  out_tvalid & out_tready   setpoint or path-done result
//   cfg_*    in   cfg_we                    lookahead, end margin, search limit
//
// An append without last_point stores the point if there is room. A
// last_point append sweeps all stored points to trim the path, then runs an
// update. An update, unless the path is done, sweeps the trimmed path for the
// nearest point, may walk forward and fetches the target. One read port issues
// one entry per cycle into the four-stage distance pipe. Reset clears counters,
// position and output valid and loads register defaults; the point memory has
// no clearing pass. in_tready is high only while idle; a finished result waits
// in the output register; a later one holds in the sequencer until it is free.
// ----------------------------------------------------------------------------
module lookahead_waypoint_select_core import lws_pkg::*; #(
  parameter int PATH_DEPTH = 256,
  parameter int COORD_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // coord_x, coord_y, coord_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // action, first_point
  input  logic [1:0]                            in_tuser,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // target_index, target_x, target_y, target_z
  output logic [((TIDX_W+3*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // setpoint_valid, path_done
  output logic [1:0]                            out_tuser,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_wdata
);

  localparam int N       = COORD_BITS;
  localparam int AW      = $clog2(PATH_DEPTH);
  localparam int OUT_TDW = ((TIDX_W + 3 * N + 7) / 8) * 8;

  logic [LOOK_W-1:0]     look_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic [LOOK_SQ_W-1:0]  look_sq_r;
  logic [LIMIT_SQ_W-1:0] limit_sq;
  logic [N-1:0]          pos_x_r, pos_y_r, pos_z_r;
  logic                  out_valid_r;
  logic [1:0]            out_user_r;
  logic [TIDX_W+3*N-1:0] out_data_r;

  logic                  in_xfer, out_free;
  logic [3*N-1:0]        in_coords;
  logic                  mem_we, mem_re, flush;
  logic [AW-1:0]         mem_waddr, mem_raddr, iss_addr, res_addr;
  logic [3*N-1:0]        mem_wdata, mem_rdata;
  lws_tag_t              iss_tag, res_tag;
  logic [2*N+1:0]        res_d2, res_d3;
  lws_res_t              res_out;
  logic [TIDX_W-1:0]     res_index;
  logic [3*N-1:0]        res_coords;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_coords = in_tdata[3*N-1:0];
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r   <= LOOK_RST;
      margin_r <= MARGIN_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOKAHEAD: look_r   <= cfg_wdata[LOOK_W-1:0];
        CFG_MARGIN:    margin_r <= cfg_wdata[MARGIN_W-1:0];
        CFG_LIMIT:     limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default:       look_r   <= look_r;
      endcase
    end
  end

  // lookahead square is first needed well after an item is taken
  always_ff @(posedge clk) begin
    look_sq_r <= LOOK_SQ_W'(look_r) * LOOK_SQ_W'(look_r);
  end

  assign limit_sq = LIMIT_SQ_W'(limit_r) * LIMIT_SQ_W'(limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else if (in_xfer && (in_tuser[0] == ACT_UPDATE)) begin
      pos_x_r <= in_coords[N-1:0];
      pos_y_r <= in_coords[2*N-1:N];
      pos_z_r <= in_coords[3*N-1:2*N];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_out.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_out.load) begin
      out_user_r <= {res_out.path_done, res_out.setpoint_valid};
      out_data_r <= {res_coords, res_index};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = OUT_TDW'(out_data_r);

  lws_point_mem #(
    .DEPTH (PATH_DEPTH),
    .WIDTH (3 * COORD_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  lws_dist_pipe #(
    .COORD_BITS (COORD_BITS),
    .AW         (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .iss_tag  (iss_tag),
    .iss_addr (iss_addr),
    .rd_data  (mem_rdata),
    .pos_x    (pos_x_r),
    .pos_y    (pos_y_r),
    .pos_z    (pos_z_r),
    .res_tag  (res_tag),
    .res_addr (res_addr),
    .res_d2   (res_d2),
    .res_d3   (res_d3)
  );

  lws_ctrl #(
    .PATH_DEPTH (PATH_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_xfer    (in_xfer),
    .in_action  (in_tuser[0]),
    .in_first   (in_tuser[1]),
    .in_last    (in_tlast),
    .in_coords  (in_coords),
    .look_sq    (look_sq_r),
    .limit_sq   (limit_sq),
    .end_margin (margin_r),
    .in_ready   (in_tready),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .iss_tag    (iss_tag),
    .iss_addr   (iss_addr),
    .flush      (flush),
    .res_tag    (res_tag),
    .res_addr   (res_addr),
    .res_d2     (res_d2),
    .res_d3     (res_d3),
    .out_free   (out_free),
    .res_out    (res_out),
    .res_index  (res_index),
    .res_coords (res_coords)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lookahead waypoint selector. A predictor holds
// its own copy of the point store, path pointers, position and registers, and
// queues the expected setpoint or path-done result of every accepted update or
// last-point append. Directed loads and updates come first. Random path loads,
// tracking sequences and noise follow, under a sweep of register settings.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lws_pkg::*;

  localparam int PATH_DEPTH    = 256;
  localparam int COORD_BITS    = 24;
  localparam int IN_W          = ((3*COORD_BITS+7)/8)*8;
  localparam int OUT_W         = ((TIDX_W+3*COORD_BITS+7)/8)*8;
  localparam int ITEM_GOAL     = 1150;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_CYCLES  = 1200;
  localparam int REPORT_MAX    = 10;
  localparam longint unsigned LIMIT_CYCLES = 64'd4000000;
  localparam longint unsigned DIST_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned LOOK_MAX  = (1 << LOOK_W) - 1;
  localparam int unsigned LIMIT_MAX = (1 << LIMIT_W) - 1;
  localparam int unsigned MARGIN_MAX = (1 << MARGIN_W) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   action;
    logic   first_point;
    logic   last_point;
    coord_t x;
    coord_t y;
    coord_t z;
  } path_cmd_t;

  typedef struct packed {
    logic              setpoint_valid;
    logic              path_done;
    logic [TIDX_W-1:0] target_index;
    coord_t            x;
    coord_t            y;
    coord_t            z;
  } setpoint_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // coord_x, coord_y, coord_z
  logic [IN_W-1:0]      in_tdata;
  // action, first_point
  logic [1:0]           in_tuser;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // target_index, target_x, target_y, target_z
  logic [OUT_W-1:0]     out_tdata;
  // setpoint_valid, path_done
  logic [1:0]           out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  lookahead_waypoint_select_core #(
    .PATH_DEPTH(PATH_DEPTH),
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  int unsigned look_dist;
  int unsigned margin;
  int unsigned limit;
  coord_t      wp_x [PATH_DEPTH];
  coord_t      wp_y [PATH_DEPTH];
  coord_t      wp_z [PATH_DEPTH];
  int unsigned path_len;
  int unsigned path_base;
  int unsigned track_idx;
  coord_t      pos_x;
  coord_t      pos_y;
  coord_t      pos_z;

  setpoint_t setpoint_q [$];

  int unsigned     items_sent;
  int unsigned     results_seen;
  int unsigned     setpoints_seen;
  int unsigned     paths_ended;
  int unsigned     mismatches;
  int unsigned     settings_used;
  int              burst_left;
  longint unsigned cycles;
  int unsigned     rx_mode;
  int unsigned     rx_left;

  function automatic longint unsigned sq_gap(coord_t a, coord_t b);
    longint          d;
    longint unsigned u;
    d = longint'(a) - longint'(b);
    u = (d < 0) ? -d : d;
    if (u >= 64'h1_0000_0000) return DIST_MAX;
    return u * u;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    return (a > ~b) ? DIST_MAX : a + b;
  endfunction

  function automatic longint unsigned plane_dist(int unsigned s);
    return sat_sum(sq_gap(wp_x[s], pos_x), sq_gap(wp_y[s], pos_y));
  endfunction

  function automatic longint unsigned space_dist(int unsigned s);
    return sat_sum(plane_dist(s), sq_gap(wp_z[s], pos_z));
  endfunction

  // first 2D minimum in [from, upto), relative to from; 0 if none beats the limit
  function automatic int unsigned nearest_point(int unsigned from, int unsigned upto);
    longint unsigned best;
    longint unsigned d;
    int unsigned     bi;
    best = 64'(limit) * 64'(limit);
    bi = 0;
    for (int unsigned s = from; s < upto && s < PATH_DEPTH; s++) begin
      d = plane_dist(s);
      if (d < best) begin
        best = d;
        bi = s - from;
      end
    end
    return bi;
  endfunction

  function automatic setpoint_t select_setpoint();
    setpoint_t       r;
    int unsigned     span;
    int unsigned     closest;
    int unsigned     hop;
    int unsigned     idx;
    int unsigned     s;
    longint unsigned d;
    longint unsigned reach;
    r = '0;
    span = (path_len > path_base) ? path_len - path_base : 0;
    if (span > track_idx + margin) begin
      reach = 64'(look_dist) * 64'(look_dist);
      closest = nearest_point(path_base, path_len);
      hop = 0;
      d = 0;
      // walk forward until the lookahead is reached or the path ends
      while (d < reach && closest + hop < span - 1) begin
        hop++;
        d = space_dist((path_base + closest + hop) % PATH_DEPTH);
      end
      idx = (closest + hop >= span - 1) ? span - 1 : closest + hop;
      track_idx = idx;
      s = (path_base + idx) % PATH_DEPTH;
      r.setpoint_valid = 1'b1;
      r.target_index = idx[TIDX_W-1:0];
      r.x = wp_x[s];
      r.y = wp_y[s];
      r.z = wp_z[s];
    end else begin
      path_len = 0;
      path_base = 0;
      track_idx = 0;
      r.path_done = 1'b1;
    end
    return r;
  endfunction

  function automatic bit apply_cmd(path_cmd_t c, output setpoint_t r);
    r = '0;
    if (c.action == ACT_UPDATE) begin
      pos_x = c.x;
      pos_y = c.y;
      pos_z = c.z;
      r = select_setpoint();
      return 1'b1;
    end
    if (c.first_point) begin
      path_len = 0;
      path_base = 0;
      track_idx = 0;
    end
    // drop points once the store is full
    if (path_len < PATH_DEPTH) begin
      wp_x[path_len] = c.x;
      wp_y[path_len] = c.y;
      wp_z[path_len] = c.z;
      path_len++;
    end
    if (c.last_point) begin
      path_base = nearest_point(0, path_len);
      track_idx = 0;
      r = select_setpoint();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic path_cmd_t make_cmd(logic action, logic first, logic last,
                                         coord_t x, coord_t y, coord_t z);
    path_cmd_t c;
    c.action = action;
    c.first_point = first;
    c.last_point = last;
    c.x = x;
    c.y = y;
    c.z = z;
    return c;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      1:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t jitter(int unsigned spread);
    return coord_t'(int'($urandom_range(0, 2*spread)) - int'(spread));
  endfunction

  task automatic send_cmd(path_cmd_t c);
    setpoint_t r;
    int        gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c.z, c.y, c.x};
    in_tuser  <= {c.first_point, c.action};
    in_tlast  <= c.last_point;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
    if (apply_cmd(c, r)) setpoint_q.push_back(r);
  endtask

  // hold off until every pending result is out and the block is idle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (setpoint_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_LOOKAHEAD: look_dist = value[LOOK_W-1:0];
      CFG_MARGIN:    margin    = value[MARGIN_W-1:0];
      CFG_LIMIT:     limit     = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int unsigned look, int unsigned marg, int unsigned lim);
    drain_results();
    write_reg(CFG_LOOKAHEAD, look);
    write_reg(CFG_MARGIN, marg);
    write_reg(CFG_LIMIT, lim);
    settings_used++;
  endtask

  // load a path of npts points, then track it with nupd position updates
  task automatic run_path(int unsigned npts, int unsigned nupd, int unsigned spacing,
                          int unsigned stride);
    coord_t      px [PATH_DEPTH+8];
    coord_t      py [PATH_DEPTH+8];
    coord_t      pz [PATH_DEPTH+8];
    int unsigned at;
    if ($urandom_range(0, 5) == 0) begin
      px[0] = rand_coord();
      py[0] = rand_coord();
      pz[0] = rand_coord();
    end else begin
      px[0] = jitter(1 << 20);
      py[0] = jitter(1 << 20);
      pz[0] = jitter(1 << 16);
    end
    for (int unsigned i = 1; i < npts; i++) begin
      px[i] = px[i-1] + coord_t'($urandom_range(0, 2*spacing));
      py[i] = py[i-1] + jitter(spacing);
      pz[i] = pz[i-1] + jitter(spacing / 4);
    end
    // park the position at the start so the trim keeps the whole path
    if ($urandom_range(0, 1) == 0)
      send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, px[0], py[0], pz[0]));
    for (int unsigned i = 0; i < npts; i++)
      send_cmd(make_cmd(ACT_APPEND, i == 0, i == npts - 1, px[i], py[i], pz[i]));
    at = 0;
    for (int unsigned k = 0; k < nupd; k++) begin
      at = at + $urandom_range(0, stride);
      if (at >= npts) at = npts - 1;
      if ($urandom_range(0, 9) == 0)
        send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, rand_coord(), rand_coord(), rand_coord()));
      else
        send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, px[at] + jitter(48), py[at] + jitter(48),
                          pz[at] + jitter(16)));
    end
  endtask

  task automatic run_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_cmd(make_cmd($urandom_range(0, 1), $urandom_range(0, 3) == 0,
                        $urandom_range(0, 5) == 0, rand_coord(), rand_coord(), rand_coord()));
  endtask

  task automatic test_empty_path();
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, {1'b0, {(COORD_BITS-1){1'b1}}},
                      {1'b0, {(COORD_BITS-1){1'b1}}}, {1'b0, {(COORD_BITS-1){1'b1}}}));
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, {1'b1, {(COORD_BITS-1){1'b0}}},
                      {1'b1, {(COORD_BITS-1){1'b0}}}, {1'b1, {(COORD_BITS-1){1'b0}}}));
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, '0, '0, '0));
  endtask

  // straight path from the origin; ends at the far corner of the coordinate range
  task automatic test_short_path();
    coord_t cmax;
    coord_t cmin;
    cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
    cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
    for (int i = 0; i < 13; i++)
      send_cmd(make_cmd(ACT_APPEND, i == 0, 1'b0, coord_t'(i*100), coord_t'(i*20),
                        coord_t'(-i*10)));
    send_cmd(make_cmd(ACT_APPEND, 1'b0, 1'b1, cmax, cmax, cmax));
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, 250, 40, 0));
    // no point within the search limit: nearest falls back to the path start
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, cmin, cmin, cmin));
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, 600, 120, -60));
  endtask

  task automatic test_single_point();
    send_cmd(make_cmd(ACT_APPEND, 1'b1, 1'b1, rand_coord(), rand_coord(), rand_coord()));
  endtask

  // overfill the store; the last flag on a dropped point still trims
  task automatic test_store_full();
    run_path(PATH_DEPTH + 4, 12, 40, 24);
  endtask

  // updates while a load is in progress, then appends that continue the store
  task automatic test_interleaved_load();
    coord_t x0;
    coord_t y0;
    int     n;
    x0 = jitter(1 << 20);
    y0 = jitter(1 << 20);
    n = $urandom_range(8, 16);
    for (int i = 0; i < n; i++)
      send_cmd(make_cmd(ACT_APPEND, i == 0, 1'b0, x0 + coord_t'(i*60), y0, coord_t'(i)));
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, x0 + jitter(100), y0 + jitter(100), 0));
    for (int i = n; i < n + 6; i++)
      send_cmd(make_cmd(ACT_APPEND, 1'b0, 1'b0, x0 + coord_t'(i*60), y0, coord_t'(i)));
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, x0 + coord_t'(n*30), y0, 0));
    send_cmd(make_cmd(ACT_APPEND, 1'b0, 1'b1, x0 + coord_t'((n+6)*60), y0, 0));
    send_cmd(make_cmd(ACT_UPDATE, 1'b0, 1'b0, x0 + coord_t'(n*60), y0 + jitter(30), 0));
  endtask

  task automatic test_config_sweep();
    int unsigned start_count;
    int unsigned phase_end;
    int unsigned pick;
    start_count = items_sent;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(LOOK_RST, MARGIN_RST, LIMIT_RST);
        1: set_config(0, 0, LIMIT_MAX);
        2: set_config(LOOK_MAX, 0, LIMIT_MAX);
        3: set_config(LOOK_MAX, MARGIN_MAX, 0);
        4: set_config($urandom_range(64, 1200), $urandom_range(0, 12),
                      $urandom_range(500, 200000));
        5: set_config($urandom_range(0, LOOK_MAX), $urandom_range(0, 4),
                      $urandom_range(0, LIMIT_MAX));
        default: set_config($urandom_range(100, 2000), $urandom_range(0, 20),
                            $urandom_range(0, LIMIT_MAX));
      endcase
      phase_end = items_sent + ((p == 3) ? 30 : (ITEM_GOAL - start_count - 30) / 6);
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 11);
        if (pick < 2)
          run_noise($urandom_range(5, 15));
        else if (pick == 2)
          test_interleaved_load();
        else if (pick == 3)
          run_path($urandom_range(120, PATH_DEPTH), $urandom_range(3, 10),
                   $urandom_range(10, 200), 24);
        else
          run_path($urandom_range(2, 40), $urandom_range(2, 14),
                   $urandom_range(10, 200), 3);
      end
    end
  endtask

  // receiver: switch between always ready, mostly ready and stalled stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(8, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : result_check
    setpoint_t want;
    setpoint_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.setpoint_valid = out_tuser[0];
      got.path_done      = out_tuser[1];
      got.target_index   = out_tdata[TIDX_W-1:0];
      got.x              = out_tdata[TIDX_W +: COORD_BITS];
      got.y              = out_tdata[TIDX_W+COORD_BITS +: COORD_BITS];
      got.z              = out_tdata[TIDX_W+2*COORD_BITS +: COORD_BITS];
      results_seen++;
      if (setpoint_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result transfer with nothing pending: valid=%0b done=%0b idx=%0d",
                   $time, got.setpoint_valid, got.path_done, got.target_index);
      end else begin
        want = setpoint_q.pop_front();
        if (want.setpoint_valid) setpoints_seen++;
        if (want.path_done) paths_ended++;
        if (got.setpoint_valid !== want.setpoint_valid || got.path_done !== want.path_done ||
            got.target_index !== want.target_index || got.x !== want.x ||
            got.y !== want.y || got.z !== want.z) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: mismatch exp valid=%0b done=%0b idx=%0d x=%0d y=%0d z=%0d", $time,
                     want.setpoint_valid, want.path_done, want.target_index,
                     want.x, want.y, want.z);
            $display("%0t:          got valid=%0b done=%0b idx=%0d x=%0d y=%0d z=%0d", $time,
                     got.setpoint_valid, got.path_done, got.target_index,
                     got.x, got.y, got.z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("watchdog expired after %0d cycles, %0d results pending", cycles,
               setpoint_q.size());
      $display("lookahead_waypoint_select_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    look_dist  = LOOK_RST;
    margin     = MARGIN_RST;
    limit      = LIMIT_RST;
    path_len   = 0;
    path_base  = 0;
    track_idx  = 0;
    pos_x      = '0;
    pos_y      = '0;
    pos_z      = '0;
    burst_left = 0;
    cycles     = 0;
    rx_mode    = 0;
    rx_left    = 0;
    items_sent = 0;
    results_seen   = 0;
    setpoints_seen = 0;
    paths_ended    = 0;
    mismatches     = 0;
    settings_used  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_path();
    test_short_path();
    test_single_point();
    test_store_full();
    test_interleaved_load();
    test_config_sweep();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input transfers and %0d results: %0d setpoints, %0d path ends",
             items_sent, results_seen, setpoints_seen, paths_ended);
    $display("register settings: %0d, mismatches: %0d, results never seen: %0d",
             settings_used + 1, mismatches, setpoint_q.size());
    if (mismatches == 0 && setpoint_q.size() == 0) begin
      $display("lookahead_waypoint_select_core regression: pass");
    end else begin
      $display("lookahead_waypoint_select_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/lws_pkg.sv
design/lws_point_mem.sv
design/lws_dist_pipe.sv
design/lws_ctrl.sv
design/lookahead_waypoint_select_core.sv
test/tb_top.sv
